@@ rtl/bmhq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions of the binary min-heap queue
// Command and status codes, key limits and the result record that the
// controller hands to the output stage.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 4;
    localparam int ST_W      = 3;
    localparam int CNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY       = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_INDEX   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_SMALLER = 3'd4;

    // Reported as value and as min_key when nothing applies.
    localparam logic signed [KEY_W-1:0] KEY_NONE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]    count;
        logic signed [KEY_W-1:0] min_key;
        logic [ST_W-1:0]         status;
        logic signed [KEY_W-1:0] value;
    } result_t;

endpackage

@@ rtl/bmhq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram: heap entry storage
// Single write port and single read port; read data is registered, so it
// appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [bmhq_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [bmhq_pkg::KEY_W-1:0] rdata
);

    logic signed [bmhq_pkg::KEY_W-1:0] heap_mem [DEPTH];
    logic signed [bmhq_pkg::KEY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rdata_reg <= heap_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bmhq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ctrl: command sequencer of the binary min-heap queue
// Runs sift-up and sift-down as read, compare and write-back steps against
// the heap memory, carrying the moving key in a register (hole method).
// ----------------------------------------------------------------------------
module bmhq_ctrl #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bmhq_pkg::CMD_W-1:0]        in_cmd,
    input  logic signed [bmhq_pkg::KEY_W-1:0] in_key,
    input  logic [bmhq_pkg::IDX_W-1:0]        in_idx,
    output logic                              res_valid,
    input  logic                              res_ready,
    output bmhq_pkg::result_t                 res,
    output logic                              mem_we,
    output logic [AW-1:0]                     mem_waddr,
    output logic signed [bmhq_pkg::KEY_W-1:0] mem_wdata,
    output logic [AW-1:0]                     mem_raddr,
    input  logic signed [bmhq_pkg::KEY_W-1:0] mem_rdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = AW + 2;
    localparam int CMPW = (CW > bmhq_pkg::IDX_W) ? CW : bmhq_pkg::IDX_W;
    localparam int OW   = (CW > bmhq_pkg::CNT_OUT_W) ? CW : bmhq_pkg::CNT_OUT_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_IDX_WAIT = 4'd1;
    localparam logic [3:0] S_UP_CHK   = 4'd2;
    localparam logic [3:0] S_UP_CMP   = 4'd3;
    localparam logic [3:0] S_DN_LAST  = 4'd4;
    localparam logic [3:0] S_DN_CHK   = 4'd5;
    localparam logic [3:0] S_DN_LW    = 4'd6;
    localparam logic [3:0] S_DN_RW    = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0]                        state_reg,  state_next;
    logic [CW-1:0]                     count_reg,  count_next;
    logic [AW-1:0]                     pos_reg,    pos_next;
    logic signed [bmhq_pkg::KEY_W-1:0] cur_reg,    cur_next;
    logic signed [bmhq_pkg::KEY_W-1:0] lkey_reg,   lkey_next;
    logic signed [bmhq_pkg::KEY_W-1:0] rkey_reg,   rkey_next;
    logic                              rok_reg,    rok_next;
    logic                              forced_reg, forced_next;
    logic signed [bmhq_pkg::KEY_W-1:0] value_reg,  value_next;
    logic [bmhq_pkg::ST_W-1:0]         status_reg, status_next;
    logic signed [bmhq_pkg::KEY_W-1:0] root_reg;

    logic [CW-1:0]   count_dec;
    logic [AW-1:0]   last_addr;
    logic            full;
    logic [AW-1:0]   pos_m1;
    logic [AW-1:0]   parent;
    logic [XW-1:0]   count_x;
    logic [XW-1:0]   lc_x;
    logic [XW-1:0]   rc_x;
    logic [CMPW-1:0] idx_c;
    logic            idx_ok;
    logic [OW-1:0]   cnt_o;
    logic            take_l;
    logic            take_r;
    logic signed [bmhq_pkg::KEY_W-1:0] small_key;

    assign count_dec = count_reg - 1'b1;
    assign last_addr = count_dec[AW-1:0];
    assign full      = (count_reg == CW'(CAPACITY));
    assign pos_m1    = pos_reg - 1'b1;
    assign parent    = pos_m1 >> 1;
    assign count_x   = XW'(count_reg);
    assign lc_x      = {1'b0, pos_reg, 1'b1};
    assign rc_x      = {1'b0, pos_reg, 1'b0} + XW'(2);
    assign idx_c     = CMPW'(in_idx);
    assign idx_ok    = idx_c < CMPW'(count_reg);
    assign cnt_o     = OW'(count_reg);

    // Child selection: the left child wins over an equal right child.
    assign take_l    = lkey_reg < cur_reg;
    assign small_key = take_l ? lkey_reg : cur_reg;
    assign take_r    = rok_reg && (rkey_reg < small_key);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        lkey_next   = lkey_reg;
        rkey_next   = rkey_reg;
        rok_next    = rok_reg;
        forced_next = forced_reg;
        value_next  = value_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = cur_reg;
        mem_raddr   = pos_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    value_next  = bmhq_pkg::KEY_NONE;
                    status_next = bmhq_pkg::ST_OK;
                    forced_next = 1'b0;
                    unique case (in_cmd)
                        bmhq_pkg::CMD_INSERT: begin
                            if (full) begin
                                status_next = bmhq_pkg::ST_OVERFLOW;
                                state_next  = S_FIN;
                            end else begin
                                cur_next   = in_key;
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + 1'b1;
                                state_next = S_UP_CHK;
                            end
                        end
                        bmhq_pkg::CMD_EXTRACT: begin
                            if (count_reg == '0) begin
                                status_next = bmhq_pkg::ST_EMPTY;
                                state_next  = S_FIN;
                            end else begin
                                value_next = root_reg;
                                count_next = count_dec;
                                pos_next   = '0;
                                mem_raddr  = last_addr;
                                state_next = (count_dec == '0) ? S_FIN : S_DN_LAST;
                            end
                        end
                        default: begin
                            if (!idx_ok) begin
                                status_next = bmhq_pkg::ST_BAD_INDEX;
                                state_next  = S_FIN;
                            end else begin
                                mem_raddr   = idx_c[AW-1:0];
                                pos_next    = idx_c[AW-1:0];
                                cur_next    = in_key;
                                forced_next = (in_cmd == bmhq_pkg::CMD_DELETE);
                                state_next  = S_IDX_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_IDX_WAIT: begin
                if (forced_reg) begin
                    value_next = mem_rdata;
                    state_next = S_UP_CHK;
                end else if (cur_reg > mem_rdata) begin
                    status_next = bmhq_pkg::ST_NOT_SMALLER;
                    state_next  = S_FIN;
                end else begin
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (pos_reg == '0) begin
                    if (forced_reg) begin
                        // Deleted entry now sits at the root: remove it.
                        count_next = count_dec;
                        mem_raddr  = last_addr;
                        state_next = (count_dec == '0) ? S_FIN : S_DN_LAST;
                    end else begin
                        mem_we     = 1'b1;
                        state_next = S_FIN;
                    end
                end else begin
                    mem_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (forced_reg || (mem_rdata > cur_reg)) begin
                    mem_wdata  = mem_rdata;
                    pos_next   = parent;
                    state_next = S_UP_CHK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DN_LAST: begin
                cur_next   = mem_rdata;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (lc_x >= count_x) begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end else begin
                    mem_raddr  = lc_x[AW-1:0];
                    state_next = S_DN_LW;
                end
            end
            S_DN_LW: begin
                lkey_next = mem_rdata;
                if (rc_x < count_x) begin
                    mem_raddr  = rc_x[AW-1:0];
                    rok_next   = 1'b1;
                    state_next = S_DN_RW;
                end else begin
                    rok_next   = 1'b0;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RW: begin
                rkey_next  = mem_rdata;
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (take_r) begin
                    mem_wdata  = rkey_reg;
                    pos_next   = rc_x[AW-1:0];
                    state_next = S_DN_CHK;
                end else if (take_l) begin
                    mem_wdata  = lkey_reg;
                    pos_next   = lc_x[AW-1:0];
                    state_next = S_DN_CHK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        lkey_reg   <= lkey_next;
        rkey_reg   <= rkey_next;
        rok_reg    <= rok_next;
        forced_reg <= forced_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        // Shadow copy of the root entry for the min_key report.
        if (mem_we && (mem_waddr == '0)) begin
            root_reg <= mem_wdata;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);

    assign res.value   = value_reg;
    assign res.status  = status_reg;
    assign res.min_key = (count_reg == '0) ? bmhq_pkg::KEY_NONE : root_reg;
    assign res.count   = cnt_o[bmhq_pkg::CNT_OUT_W-1:0];

endmodule

@@ rtl/binary_min_heap_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core: priority queue of signed 32-bit keys
// Array-based binary min-heap held in a synchronous memory, with insert,
// extract-minimum, decrease-key and delete-at-position commands.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                     | Payload (lowest bit first)
//  ---------+---------------------------+-----------------------------------
//  command  | s_tvalid s_tready s_tdata | command[1:0] key[33:2] index[37:34]
//  result   | m_tvalid m_tready m_tdata | value status min_key count
//
// One command is worked at a time. At each heap level sift-up reads the
// parent, then compares and writes back; sift-down reads the children one
// after the other through the single read port, then compares and writes
// back. A failed command finishes without a memory write; a decrease that
// is not smaller first reads the entry that it names.
// The memory read port sets the pace.
// Reset (aresetn low, synchronous) empties the queue; the memory itself is
// not cleared, since only entries below the count are ever read.
// The result sits in an output register, so a new command transfer is taken
// while the previous result still waits on m_tready; a command only stalls
// in its last cycle if the output register is still occupied.
//
module binary_min_heap_queue_core #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: command[1:0], key[33:2], index[37:34], zero[39:38]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: value[31:0], status[34:32], min_key[66:35], count[71:67]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);

    logic                              res_valid;
    logic                              res_ready;
    bmhq_pkg::result_t                 res;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [bmhq_pkg::KEY_W-1:0] mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic signed [bmhq_pkg::KEY_W-1:0] mem_rdata;

    logic              out_valid_reg, out_valid_next;
    bmhq_pkg::result_t out_data_reg;

    bmhq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[1:0]),
        .in_key    (s_tdata[33:2]),
        .in_idx    (s_tdata[37:34]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a new result whenever it is empty or its
    // current contents are being transferred in this cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_valid && res_ready) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.count, out_data_reg.min_key,
                       out_data_reg.status, out_data_reg.value};

endmodule

@@ tb/tb_binary_min_heap_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue_core: self-checking bench for the heap queue core
// Streams insert, extract, decrease and delete commands into the core. A
// behavioral min-heap inside the bench computes the result of each command
// transfer, and every result transfer is compared field by field with it.
// The run opens with directed corner cases and continues with randomized
// fill, drain and mixed traffic. Idle cycles fall on both sides at random.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue_core;

    localparam int DEPTH       = bmhq_pkg::CAPACITY_DEF;
    localparam int IDX_BITS    = bmhq_pkg::IDX_W;
    localparam int CNT_BITS    = bmhq_pkg::CNT_OUT_W;
    localparam int GAP_MAX     = 19;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_CMDS = 1800;

    typedef struct {
        logic [bmhq_pkg::CMD_W-1:0]        op;
        logic signed [bmhq_pkg::KEY_W-1:0] key;
        logic [bmhq_pkg::IDX_W-1:0]        pos;
        int                                gap;
    } heap_cmd_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [71:0] m_tdata;

    binary_min_heap_queue_core #(
        .CAPACITY(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Bench copy of the heap, advanced once per accepted command transfer.
    logic signed [bmhq_pkg::KEY_W-1:0] heap_img [DEPTH];
    int unsigned                       heap_len = 0;

    bmhq_pkg::result_t due_results [$];
    heap_cmd_t         cmd_fifo [$];

    int cmds_issued   = 0;
    int cmds_taken    = 0;
    int results_taken = 0;
    int mismatches    = 0;
    int op_hist [4];
    int status_hist [8];
    int peak_len      = 0;

    // Driver and receiver state.
    bit          cmd_loaded = 1'b0;
    int          cmd_gap    = 0;
    logic [39:0] cmd_word   = '0;
    int          rx_wait    = 0;
    int          rx_seen    = 0;
    int          holds_served = 0;

    // Written by the stimulus process only.
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int hold_requests = 0;
    int gen_len       = 0;
    int rand_sent     = 0;

    function automatic void heap_swap(int unsigned a, int unsigned b);
        logic signed [bmhq_pkg::KEY_W-1:0] t;
        t           = heap_img[a];
        heap_img[a] = heap_img[b];
        heap_img[b] = t;
    endfunction

    // A forced walk always reaches the root, as delete needs.
    function automatic void heap_sift_up(int unsigned at, bit forced);
        int unsigned up;
        while (at != 0) begin
            up = (at - 1) / 2;
            if (!forced && !(heap_img[up] > heap_img[at]))
                break;
            heap_swap(at, up);
            at = up;
        end
    endfunction

    // Strictly smaller children only; the left child wins a tie.
    function automatic void heap_sift_down(int unsigned at);
        int unsigned best;
        int unsigned lc;
        int unsigned rc;
        forever begin
            best = at;
            lc   = 2 * at + 1;
            rc   = 2 * at + 2;
            if (lc < heap_len && heap_img[lc] < heap_img[best])
                best = lc;
            if (rc < heap_len && heap_img[rc] < heap_img[best])
                best = rc;
            if (best == at)
                break;
            heap_swap(at, best);
            at = best;
        end
    endfunction

    function automatic logic signed [bmhq_pkg::KEY_W-1:0] heap_pop_root();
        logic signed [bmhq_pkg::KEY_W-1:0] top;
        top = heap_img[0];
        heap_len--;
        if (heap_len > 0) begin
            heap_img[0] = heap_img[heap_len];
            heap_sift_down(0);
        end
        return top;
    endfunction

    function automatic bmhq_pkg::result_t heap_execute(
            logic [bmhq_pkg::CMD_W-1:0] op,
            logic signed [bmhq_pkg::KEY_W-1:0] k,
            logic [bmhq_pkg::IDX_W-1:0] pos);
        bmhq_pkg::result_t r;
        r.value  = bmhq_pkg::KEY_NONE;
        r.status = bmhq_pkg::ST_OK;
        case (op)
            bmhq_pkg::CMD_INSERT: begin
                if (heap_len >= DEPTH) begin
                    r.status = bmhq_pkg::ST_OVERFLOW;
                end else begin
                    heap_img[heap_len] = k;
                    heap_len++;
                    heap_sift_up(heap_len - 1, 1'b0);
                end
            end
            bmhq_pkg::CMD_EXTRACT: begin
                if (heap_len == 0)
                    r.status = bmhq_pkg::ST_EMPTY;
                else
                    r.value = heap_pop_root();
            end
            default: begin
                if (pos >= heap_len) begin
                    r.status = bmhq_pkg::ST_BAD_INDEX;
                end else if (op == bmhq_pkg::CMD_DECREASE) begin
                    if (k > heap_img[pos]) begin
                        r.status = bmhq_pkg::ST_NOT_SMALLER;
                    end else begin
                        heap_img[pos] = k;
                        heap_sift_up(32'(pos), 1'b0);
                    end
                end else begin
                    // Delete: lift the entry to the root, then remove the root.
                    r.value = heap_img[pos];
                    heap_sift_up(32'(pos), 1'b1);
                    void'(heap_pop_root());
                end
            end
        endcase
        r.min_key = (heap_len > 0) ? heap_img[0] : bmhq_pkg::KEY_NONE;
        r.count   = CNT_BITS'(heap_len);
        return r;
    endfunction

    function automatic void note_mismatch(string field, longint want, longint got);
        mismatches++;
        $error("result %0d field %s: expected %0d, got %0d",
               results_taken, field, want, got);
    endfunction

    // Both channels are sampled here. A command is applied to the bench heap
    // before the result check; a result never leaves in the cycle that its
    // own command is taken, so the order inside this block does not matter.
    always @(posedge aclk) begin : monitor
        bmhq_pkg::result_t want;
        bmhq_pkg::result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = heap_execute(s_tdata[1:0], s_tdata[33:2], s_tdata[37:34]);
                due_results.push_back(want);
                op_hist[s_tdata[1:0]]++;
                if (heap_len > peak_len)
                    peak_len = heap_len;
                cmds_taken++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_taken++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $error("result %0d arrived with no command waiting for it",
                           results_taken);
                end else begin
                    want = due_results.pop_front();
                    status_hist[want.status]++;
                    if (got.value !== want.value)
                        note_mismatch("value", want.value, got.value);
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.min_key !== want.min_key)
                        note_mismatch("min_key", want.min_key, got.min_key);
                    if (got.count !== want.count)
                        note_mismatch("count", want.count, got.count);
                end
            end
        end
    end

    // Command driver: a command is held until its transfer, then the next one
    // is loaded and waits out its own gap before it is offered.
    always @(negedge aclk) begin : driver
        heap_cmd_t c;
        if (aresetn && cmds_taken == cmds_issued) begin
            if (!cmd_loaded && cmd_fifo.size() > 0) begin
                c          = cmd_fifo.pop_front();
                cmd_word   = {2'b00, c.pos, c.key, c.op};
                cmd_gap    = c.gap;
                cmd_loaded = 1'b1;
            end
            if (cmd_loaded && cmd_gap == 0) begin
                s_tdata    <= cmd_word;
                s_tvalid   <= 1'b1;
                cmds_issued++;
                cmd_loaded = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (cmd_loaded)
                    cmd_gap--;
            end
        end
    end

    // Result receiver: a fresh stall is drawn after each result transfer, and
    // a long hold-off is served whenever one is requested.
    always @(negedge aclk) begin : receiver
        if (results_taken != rx_seen) begin
            rx_seen = results_taken;
            rx_wait = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
        end
        if (hold_requests > holds_served) begin
            holds_served++;
            rx_wait = LONG_HOLD;
        end
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Queues one command; the fill level is tracked so that random indexes
    // can be aimed at occupied positions.
    task automatic add_cmd(logic [bmhq_pkg::CMD_W-1:0] op,
                           logic signed [bmhq_pkg::KEY_W-1:0] k,
                           logic [bmhq_pkg::IDX_W-1:0] pos);
        heap_cmd_t c;
        c.op  = op;
        c.key = k;
        c.pos = pos;
        c.gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
        cmd_fifo.push_back(c);
        case (op)
            bmhq_pkg::CMD_INSERT:  if (gen_len < DEPTH) gen_len++;
            bmhq_pkg::CMD_EXTRACT: if (gen_len > 0) gen_len--;
            bmhq_pkg::CMD_DELETE:  if (pos < gen_len) gen_len--;
            default:               ;
        endcase
    endtask

    // Mostly small keys so that ties are common, with the extremes mixed in.
    function automatic logic signed [bmhq_pkg::KEY_W-1:0] rand_key();
        int v;
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return $urandom;
            default: begin
                v = $urandom_range(0, 32);
                return v - 16;
            end
        endcase
    endfunction

    // Mode 0 fills the heap, mode 1 drains it, mode 2 mixes all four commands.
    task automatic add_random_cmd(int mode);
        int                                r;
        int                                v;
        int                                t_ins;
        int                                t_ext;
        int                                t_dec;
        logic [bmhq_pkg::CMD_W-1:0]        op;
        logic signed [bmhq_pkg::KEY_W-1:0] k;
        logic [bmhq_pkg::IDX_W-1:0]        p;
        case (mode)
            0:       begin t_ins = 60; t_ext = 70; t_dec = 85; end
            1:       begin t_ins = 15; t_ext = 60; t_dec = 75; end
            default: begin t_ins = 35; t_ext = 60; t_dec = 80; end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_ins)
            op = bmhq_pkg::CMD_INSERT;
        else if (r < t_ext)
            op = bmhq_pkg::CMD_EXTRACT;
        else if (r < t_dec)
            op = bmhq_pkg::CMD_DECREASE;
        else
            op = bmhq_pkg::CMD_DELETE;
        if (gen_len > 0 && $urandom_range(0, 6) != 0)
            p = IDX_BITS'($urandom_range(0, gen_len - 1));
        else
            p = IDX_BITS'($urandom_range(0, 15));
        k = rand_key();
        if (op == bmhq_pkg::CMD_DECREASE) begin
            case ($urandom_range(0, 4))
                0:       k = 32'sh8000_0000;
                1, 2:    begin v = $urandom_range(0, 40); k = v - 24; end
                default: ;
            endcase
        end
        add_cmd(op, k, p);
        rand_sent++;
    endtask

    // Holds the stimulus until every queued command has produced its result.
    task automatic wait_idle();
        while (cmd_fifo.size() != 0 || cmd_loaded || cmds_issued != cmds_taken
               || due_results.size() != 0)
            @(negedge aclk);
    endtask

    initial begin : stimulus
        int n;
        int mode;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Errors on an empty queue.
        add_cmd(bmhq_pkg::CMD_EXTRACT, 0, 4'd0);
        add_cmd(bmhq_pkg::CMD_DECREASE, -1, 4'd0);
        add_cmd(bmhq_pkg::CMD_DELETE, 32'sh7FFF_FFFF, 4'd15);
        // Fill to capacity with extremes and repeated keys.
        add_cmd(bmhq_pkg::CMD_INSERT, 5, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 5, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 32'sh8000_0000, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 0, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, -1, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 7, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 3, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, -7, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 12, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 5, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 100, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, -3, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 2, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 9, 4'd0);
        add_cmd(bmhq_pkg::CMD_INSERT, 1, 4'd15);
        add_cmd(bmhq_pkg::CMD_INSERT, 4, 4'd0);                 // overflow
        add_cmd(bmhq_pkg::CMD_DECREASE, 32'sh7FFF_FFFF, 4'd0);  // larger than the root
        add_cmd(bmhq_pkg::CMD_DECREASE, 32'sh8000_0000, 4'd0);  // equal to the root
        add_cmd(bmhq_pkg::CMD_DECREASE, -50, 4'd15);
        add_cmd(bmhq_pkg::CMD_DELETE, 0, 4'd15);                // last position
        add_cmd(bmhq_pkg::CMD_DELETE, 0, 4'd4);
        add_cmd(bmhq_pkg::CMD_DELETE, 0, 4'd15);                // index now past the count
        add_cmd(bmhq_pkg::CMD_EXTRACT, 0, 4'd0);
        wait_idle();

        // The receiver holds off while commands stream in back to back, so the
        // output register fills and the command channel stalls.
        tx_idle_on = 1'b0;
        hold_requests++;
        repeat (40) add_random_cmd(2);
        wait_idle();

        while (rand_sent < RANDOM_CMDS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            mode       = $urandom_range(0, 2);
            n          = $urandom_range(20, 60);
            repeat (n) add_random_cmd(mode);
            if ($urandom_range(0, 4) == 0)
                wait_idle();
            else
                while (cmd_fifo.size() > 4) @(negedge aclk);
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (due_results.size() != 0) begin
            mismatches++;
            $error("%0d expected results never arrived", due_results.size());
        end
        $display("Ran %0d commands: %0d insert, %0d extract, %0d decrease, %0d delete;",
                 cmds_taken, op_hist[bmhq_pkg::CMD_INSERT],
                 op_hist[bmhq_pkg::CMD_EXTRACT], op_hist[bmhq_pkg::CMD_DECREASE],
                 op_hist[bmhq_pkg::CMD_DELETE]);
        $display("peak fill %0d of %0d; statuses seen: ok %0d, overflow %0d,",
                 peak_len, DEPTH, status_hist[bmhq_pkg::ST_OK],
                 status_hist[bmhq_pkg::ST_OVERFLOW]);
        $display("empty %0d, bad index %0d, not smaller %0d.",
                 status_hist[bmhq_pkg::ST_EMPTY], status_hist[bmhq_pkg::ST_BAD_INDEX],
                 status_hist[bmhq_pkg::ST_NOT_SMALLER]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
